// ===== rtl/fmce_pkg.sv =====
// shared types, constants and functions for the frame mic cmac engine
`default_nettype none
package fmce_pkg;

    localparam int KEY_W = 64;
    localparam int BLK_W = 128;
    localparam int CFG_IDX_W = 3;

    localparam logic [CFG_IDX_W-1:0] REG_NET_KEY_HIGH = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_NET_KEY_LOW  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_DEV_KEY_HIGH = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_DEV_KEY_LOW  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_DEV_ADDR     = 3'd4;

    localparam logic [7:0] B0_TAG = 8'h49;
    localparam logic [7:0] PAD_BYTE = 8'h80;
    localparam logic [7:0] CMAC_RB = 8'h87;
    localparam logic [7:0] MIC_LEN = 8'd4;
    localparam logic [3:0] LAST_ROUND = 4'd10;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_DISPATCH,
        ST_SUB,
        ST_SUB_WAIT,
        ST_ABS,
        ST_ABS_WAIT,
        ST_ABS_XOR,
        ST_AFTER,
        ST_FIN,
        ST_FIN_WAIT,
        ST_LASTCHK,
        ST_EMIT
    } ctrl_state_t;

    typedef enum logic [1:0] {
        SRC_ZERO,
        SRC_CHAIN,
        SRC_FINAL
    } aes_src_t;

    typedef struct packed {
        logic     accept;
        logic     aes_start;
        aes_src_t aes_src;
        logic     sub_load;
        logic     absorb;
        logic     chain_load;
        logic     set_done;
        logic     emit;
    } fmce_cmd_t;

    typedef struct packed {
        logic lat_first;
        logic lat_last;
        logic in_frame;
        logic done;
        logic pos_lt_mlen;
        logic need_enc;
        logic at_end;
        logic mlen_zero;
        logic aes_done;
        logic out_busy;
    } fmce_stat_t;

    localparam logic [7:0] SBOX [256] = '{
        8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
        8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
        8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
        8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
        8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
        8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
        8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
        8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
        8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
        8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
        8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
        8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
        8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
        8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
        8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
        8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
    };

    function automatic logic [7:0] sbox_f(input logic [7:0] v);
        return SBOX[v];
    endfunction

    function automatic logic [7:0] xtime_f(input logic [7:0] v);
        return {v[6:0], 1'b0} ^ (v[7] ? 8'h1b : 8'h00);
    endfunction

    // gf(2^128) doubling, byte 0 in the top bits
    function automatic logic [BLK_W-1:0] dbl_f(input logic [BLK_W-1:0] v);
        return {v[BLK_W-2:0], 1'b0} ^ {{(BLK_W-8){1'b0}}, (v[BLK_W-1] ? CMAC_RB : 8'h00)};
    endfunction

endpackage
`default_nettype wire

// ===== rtl/fmce_in_if.sv =====
// input item channel of the frame mic cmac engine
`default_nettype none
interface fmce_in_if;
    logic        valid;
    logic        ready;
    logic [7:0]  data_byte;
    logic        first_byte;
    logic        last_byte;
    logic        join_mode;
    logic        downlink;
    logic [31:0] frame_count;
    logic [7:0]  total_len;

    modport source (output valid, data_byte, first_byte, last_byte, join_mode, downlink,
                    frame_count, total_len, input ready);
    modport sink (input valid, data_byte, first_byte, last_byte, join_mode, downlink,
                  frame_count, total_len, output ready);
endinterface
`default_nettype wire

// ===== rtl/fmce_out_if.sv =====
// result item channel of the frame mic cmac engine
`default_nettype none
interface fmce_out_if;
    logic        valid;
    logic        ready;
    logic [31:0] mic;
    logic        mic_match;

    modport source (output valid, mic, mic_match, input ready);
    modport sink (input valid, mic, mic_match, output ready);
endinterface
`default_nettype wire

// ===== rtl/fmce_aes.sv =====
// iterative aes-128 encryption unit, one round per cycle
`default_nettype none
module fmce_aes
    import fmce_pkg::*;
(
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             start,
    input  wire logic [BLK_W-1:0] block_in,
    input  wire logic [BLK_W-1:0] key_in,
    output logic                  done,
    output logic [BLK_W-1:0]      result
);

    logic [BLK_W-1:0] s_reg, s_next;
    logic [BLK_W-1:0] rk_reg, rk_next;
    logic [7:0]       rcon_reg, rcon_next;
    logic [3:0]       round_reg, round_next;
    logic             busy_reg, busy_next;
    logic             done_reg, done_next;

    logic [7:0] sb [16];
    logic [7:0] kb [16];
    logic [7:0] t  [16];
    logic [7:0] m  [16];
    logic [7:0] nk [16];
    logic [7:0] tmp [4];
    logic [BLK_W-1:0] round_out;
    logic [BLK_W-1:0] rk_out;

    always_comb
    begin
        for (int i = 0; i < 16; i++)
        begin
            sb[i] = s_reg[BLK_W-1-8*i -: 8];
            kb[i] = rk_reg[BLK_W-1-8*i -: 8];
        end
        for (int c = 0; c < 4; c++)
        begin
            for (int i = 0; i < 4; i++)
            begin
                t[i+4*c] = sbox_f(sb[i + 4*((c+i) % 4)]);
            end
        end
        for (int c = 0; c < 4; c++)
        begin
            logic [7:0] all;
            all = t[4*c] ^ t[4*c+1] ^ t[4*c+2] ^ t[4*c+3];
            if (round_reg != LAST_ROUND)
            begin
                m[4*c]   = t[4*c]   ^ all ^ xtime_f(t[4*c]   ^ t[4*c+1]);
                m[4*c+1] = t[4*c+1] ^ all ^ xtime_f(t[4*c+1] ^ t[4*c+2]);
                m[4*c+2] = t[4*c+2] ^ all ^ xtime_f(t[4*c+2] ^ t[4*c+3]);
                m[4*c+3] = t[4*c+3] ^ all ^ xtime_f(t[4*c+3] ^ t[4*c]);
            end
            else
            begin
                m[4*c]   = t[4*c];
                m[4*c+1] = t[4*c+1];
                m[4*c+2] = t[4*c+2];
                m[4*c+3] = t[4*c+3];
            end
        end
        tmp[0] = sbox_f(kb[13]) ^ rcon_reg;
        tmp[1] = sbox_f(kb[14]);
        tmp[2] = sbox_f(kb[15]);
        tmp[3] = sbox_f(kb[12]);
        for (int i = 0; i < 4; i++)
        begin
            nk[i] = kb[i] ^ tmp[i];
        end
        for (int i = 4; i < 16; i++)
        begin
            nk[i] = kb[i] ^ nk[i-4];
        end
        for (int i = 0; i < 16; i++)
        begin
            round_out[BLK_W-1-8*i -: 8] = m[i] ^ nk[i];
            rk_out[BLK_W-1-8*i -: 8] = nk[i];
        end
    end

    always_comb
    begin
        s_next = s_reg;
        rk_next = rk_reg;
        rcon_next = rcon_reg;
        round_next = round_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start)
        begin
            s_next = block_in ^ key_in;
            rk_next = key_in;
            rcon_next = 8'h01;
            round_next = 4'd1;
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            s_next = round_out;
            rk_next = rk_out;
            rcon_next = xtime_f(rcon_reg);
            round_next = round_reg + 4'd1;
            if (round_reg == LAST_ROUND)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            round_reg <= 4'd0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            round_reg <= round_next;
        end
    end

    always_ff @(posedge clk)
    begin
        s_reg <= s_next;
        rk_reg <= rk_next;
        rcon_reg <= rcon_next;
    end

    assign done = done_reg;
    assign result = s_reg;

endmodule
`default_nettype wire

// ===== rtl/fmce_datapath.sv =====
// datapath: keys, cmac chain, subkey, frame counters and result register
`default_nettype none
module fmce_datapath
    import fmce_pkg::*;
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 cfg_we,
    input  wire logic [CFG_IDX_W-1:0] cfg_index,
    input  wire logic [KEY_W-1:0]     cfg_data,
    input  wire logic [7:0]           data_byte,
    input  wire logic                 first_byte,
    input  wire logic                 last_byte,
    input  wire logic                 join_mode,
    input  wire logic                 downlink,
    input  wire logic [31:0]          frame_count,
    input  wire logic [7:0]           total_len,
    input  wire logic                 out_ready,
    input  wire fmce_cmd_t            cmd,
    output fmce_stat_t                stat,
    output logic                      out_valid,
    output logic [31:0]               mic,
    output logic                      mic_match
);

    logic [KEY_W-1:0] net_hi_reg, net_lo_reg, dev_hi_reg, dev_lo_reg;
    logic [31:0]      dev_addr_reg;
    logic [BLK_W-1:0] chain_reg, subkey_reg;
    logic [7:0]       pos_reg, mlen_reg;
    logic [31:0]      rmic_reg;
    logic             mode_reg, in_frame_reg, done_reg;
    logic [7:0]       byte_reg;
    logic             first_reg, last_reg, down_reg;
    logic [31:0]      fc_reg;
    logic             out_valid_reg;
    logic [31:0]      mic_reg;
    logic             match_reg;

    logic [BLK_W-1:0] key;
    logic [BLK_W-1:0] aes_in;
    logic [BLK_W-1:0] aes_res;
    logic             aes_done;
    logic [7:0]       pmin;
    logic [8:0]       cm;
    logic [3:0]       col;
    logic             pad;
    logic [BLK_W-1:0] fin_block;
    logic [BLK_W-1:0] pad_mask;
    logic [BLK_W-1:0] abs_mask;
    logic [BLK_W-1:0] b0_block;
    logic [31:0]      mic_val;

    assign key = mode_reg ? {dev_hi_reg, dev_lo_reg} : {net_hi_reg, net_lo_reg};
    assign pmin = (pos_reg < mlen_reg) ? pos_reg : mlen_reg;
    assign cm = {1'b0, pmin} + (mode_reg ? 9'd0 : 9'd16);
    assign col = cm[3:0];
    assign pad = (cm == 9'd0) || (col != 4'd0);

    always_comb
    begin
        for (int i = 0; i < 16; i++)
        begin
            pad_mask[BLK_W-1-8*i -: 8] = (pad && col == 4'(i)) ? PAD_BYTE : 8'h00;
            abs_mask[BLK_W-1-8*i -: 8] = (col == 4'(i)) ? byte_reg : 8'h00;
        end
    end

    assign fin_block = chain_reg ^ pad_mask ^ (pad ? dbl_f(subkey_reg) : subkey_reg);
    assign b0_block = {B0_TAG, 32'h0, 7'h0, down_reg,
                       dev_addr_reg[7:0], dev_addr_reg[15:8], dev_addr_reg[23:16],
                       dev_addr_reg[31:24],
                       fc_reg[7:0], fc_reg[15:8], fc_reg[23:16], fc_reg[31:24],
                       8'h00, mlen_reg};

    always_comb
    begin
        case (cmd.aes_src)
            SRC_ZERO:  aes_in = '0;
            SRC_CHAIN: aes_in = chain_reg;
            SRC_FINAL: aes_in = fin_block;
            default:   aes_in = '0;
        endcase
    end

    fmce_aes u_aes (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (cmd.aes_start),
        .block_in (aes_in),
        .key_in   (key),
        .done     (aes_done),
        .result   (aes_res)
    );

    assign mic_val = {chain_reg[103:96], chain_reg[111:104], chain_reg[119:112],
                      chain_reg[127:120]};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            net_hi_reg <= '0;
            net_lo_reg <= '0;
            dev_hi_reg <= '0;
            dev_lo_reg <= '0;
            dev_addr_reg <= '0;
            chain_reg <= '0;
            subkey_reg <= '0;
            pos_reg <= '0;
            mlen_reg <= '0;
            rmic_reg <= '0;
            mode_reg <= 1'b0;
            in_frame_reg <= 1'b0;
            done_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_index)
                    REG_NET_KEY_HIGH: net_hi_reg <= cfg_data;
                    REG_NET_KEY_LOW:  net_lo_reg <= cfg_data;
                    REG_DEV_KEY_HIGH: dev_hi_reg <= cfg_data;
                    REG_DEV_KEY_LOW:  dev_lo_reg <= cfg_data;
                    REG_DEV_ADDR:     dev_addr_reg <= cfg_data[31:0];
                    default:          ;
                endcase
            end
            if (cmd.accept && first_byte)
            begin
                mode_reg <= join_mode;
                mlen_reg <= (total_len >= MIC_LEN) ? total_len - MIC_LEN : 8'd0;
                pos_reg <= '0;
                rmic_reg <= '0;
                in_frame_reg <= 1'b1;
                done_reg <= 1'b0;
            end
            if (cmd.sub_load)
            begin
                subkey_reg <= dbl_f(aes_res);
                chain_reg <= mode_reg ? '0 : b0_block;
            end
            if (cmd.chain_load)
            begin
                chain_reg <= aes_res;
            end
            if (cmd.absorb)
            begin
                if (pos_reg < mlen_reg)
                begin
                    chain_reg <= chain_reg ^ abs_mask;
                end
                else
                begin
                    rmic_reg <= {byte_reg, rmic_reg[31:8]};
                end
                if (pos_reg != 8'hff)
                begin
                    pos_reg <= pos_reg + 8'd1;
                end
            end
            if (cmd.set_done)
            begin
                done_reg <= 1'b1;
            end
            if (cmd.emit)
            begin
                in_frame_reg <= 1'b0;
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.accept)
        begin
            byte_reg <= data_byte;
            first_reg <= first_byte;
            last_reg <= last_byte;
            if (first_byte)
            begin
                down_reg <= downlink;
                fc_reg <= frame_count;
            end
        end
        if (cmd.emit)
        begin
            mic_reg <= mic_val;
            match_reg <= (rmic_reg == mic_val);
        end
    end

    always_comb
    begin
        stat.lat_first = first_reg;
        stat.lat_last = last_reg;
        stat.in_frame = in_frame_reg;
        stat.done = done_reg;
        stat.pos_lt_mlen = pos_reg < mlen_reg;
        stat.need_enc = (cm != 9'd0) && (col == 4'd0);
        stat.at_end = pos_reg == mlen_reg;
        stat.mlen_zero = mlen_reg == 8'd0;
        stat.aes_done = aes_done;
        stat.out_busy = out_valid_reg && !out_ready;
    end

    assign out_valid = out_valid_reg;
    assign mic = mic_reg;
    assign mic_match = match_reg;

endmodule
`default_nettype wire

// ===== rtl/fmce_ctrl.sv =====
// controller state machine sequencing subkey, absorb and finalize steps
`default_nettype none
module fmce_ctrl
    import fmce_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       in_valid,
    input  wire fmce_stat_t stat,
    output logic            in_ready,
    output fmce_cmd_t       cmd
);

    ctrl_state_t state_reg, state_next;
    logic        from_first_reg, from_first_next;

    always_comb
    begin
        state_next = state_reg;
        from_first_next = from_first_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = ST_DISPATCH;
                end
            end
            ST_DISPATCH:
            begin
                if (stat.lat_first)
                begin
                    state_next = ST_SUB;
                end
                else if (stat.in_frame)
                begin
                    state_next = ST_ABS;
                end
                else
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_SUB:
            begin
                state_next = ST_SUB_WAIT;
            end
            ST_SUB_WAIT:
            begin
                if (stat.aes_done)
                begin
                    if (stat.mlen_zero)
                    begin
                        state_next = ST_FIN;
                        from_first_next = 1'b1;
                    end
                    else
                    begin
                        state_next = ST_ABS;
                    end
                end
            end
            ST_ABS:
            begin
                if (stat.pos_lt_mlen && stat.need_enc)
                begin
                    state_next = ST_ABS_WAIT;
                end
                else
                begin
                    state_next = ST_AFTER;
                end
            end
            ST_ABS_WAIT:
            begin
                if (stat.aes_done)
                begin
                    state_next = ST_ABS_XOR;
                end
            end
            ST_ABS_XOR:
            begin
                state_next = ST_AFTER;
            end
            ST_AFTER:
            begin
                if (!stat.done && stat.at_end)
                begin
                    state_next = ST_FIN;
                    from_first_next = 1'b0;
                end
                else
                begin
                    state_next = ST_LASTCHK;
                end
            end
            ST_FIN:
            begin
                state_next = ST_FIN_WAIT;
            end
            ST_FIN_WAIT:
            begin
                if (stat.aes_done)
                begin
                    state_next = from_first_reg ? ST_ABS : ST_LASTCHK;
                    from_first_next = 1'b0;
                end
            end
            ST_LASTCHK:
            begin
                if (!stat.lat_last)
                begin
                    state_next = ST_IDLE;
                end
                else if (stat.done)
                begin
                    state_next = ST_EMIT;
                end
                else
                begin
                    state_next = ST_FIN;
                    from_first_next = 1'b0;
                end
            end
            ST_EMIT:
            begin
                if (!stat.out_busy)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        in_ready = 1'b0;
        cmd = '0;
        cmd.aes_src = SRC_ZERO;
        case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                cmd.accept = in_valid;
            end
            ST_SUB:
            begin
                cmd.aes_start = 1'b1;
                cmd.aes_src = SRC_ZERO;
            end
            ST_SUB_WAIT:
            begin
                cmd.sub_load = stat.aes_done;
            end
            ST_ABS:
            begin
                if (stat.pos_lt_mlen && stat.need_enc)
                begin
                    cmd.aes_start = 1'b1;
                    cmd.aes_src = SRC_CHAIN;
                end
                else
                begin
                    cmd.absorb = 1'b1;
                end
            end
            ST_ABS_WAIT:
            begin
                cmd.chain_load = stat.aes_done;
            end
            ST_ABS_XOR:
            begin
                cmd.absorb = 1'b1;
            end
            ST_FIN:
            begin
                cmd.aes_start = 1'b1;
                cmd.aes_src = SRC_FINAL;
                cmd.set_done = 1'b1;
            end
            ST_FIN_WAIT:
            begin
                cmd.chain_load = stat.aes_done;
            end
            ST_EMIT:
            begin
                cmd.emit = !stat.out_busy;
            end
            default:
            begin
                cmd = '0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            from_first_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            from_first_reg <= from_first_next;
        end
    end

endmodule
`default_nettype wire

// ===== rtl/frame_mic_cmac_engine.sv =====
// top level of the frame mic cmac engine
//
// channel   dir  payload                                            item
// in_ch     in   data_byte first_byte last_byte join_mode           one frame byte
//                downlink frame_count total_len
// out_ch    out  mic mic_match                                      one frame result
// cfg       in   cfg_we cfg_index cfg_data                          register write
//
// one item at a time: a new byte is taken only after the last one is through
// a byte that opens a new 16-byte block first runs the iterative aes unit
// a first byte also runs the aes unit for the subkey, the final block once more
// the result register lets the next item in while a result waits
// rst_n clears control state and the key registers at once
`default_nettype none
module frame_mic_cmac_engine
    import fmce_pkg::*;
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 cfg_we,
    input  wire logic [CFG_IDX_W-1:0] cfg_index,
    input  wire logic [KEY_W-1:0]     cfg_data,
    fmce_in_if.sink                   in_ch,
    fmce_out_if.source                out_ch
);

    fmce_cmd_t  cmd;
    fmce_stat_t stat;

    fmce_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_ch.valid),
        .stat     (stat),
        .in_ready (in_ch.ready),
        .cmd      (cmd)
    );

    fmce_datapath u_dp (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_we      (cfg_we),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .data_byte   (in_ch.data_byte),
        .first_byte  (in_ch.first_byte),
        .last_byte   (in_ch.last_byte),
        .join_mode   (in_ch.join_mode),
        .downlink    (in_ch.downlink),
        .frame_count (in_ch.frame_count),
        .total_len   (in_ch.total_len),
        .out_ready   (out_ch.ready),
        .cmd         (cmd),
        .stat        (stat),
        .out_valid   (out_ch.valid),
        .mic         (out_ch.mic),
        .mic_match   (out_ch.mic_match)
    );

endmodule
`default_nettype wire

// ===== verif/fmce_tb_if.sv =====
// testbench channel file: both sides use the fmce_in_if and fmce_out_if interfaces
`timescale 1ns / 100ps

// ===== verif/frame_mic_cmac_engine_tb.sv =====
// self-checking testbench of the frame mic cmac engine: directed frames, then random frames
`timescale 1ns / 100ps
`default_nettype none
module frame_mic_cmac_engine_tb;
    import fmce_pkg::*;

    typedef struct packed {
        logic [7:0]  data_byte;
        logic        first_byte;
        logic        last_byte;
        logic        join_mode;
        logic        downlink;
        logic [31:0] frame_count;
        logic [7:0]  total_len;
    } byte_item_t;

    typedef struct packed {
        logic [31:0] mic;
        logic        mic_match;
    } mic_result_t;

    typedef struct {
        byte_item_t  item;
        logic        has_mic;
        mic_result_t mic_val;
    } dir_row_t;

    localparam int IDLE_LIMIT = 200000;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [KEY_W-1:0] cfg_data = '0;

    fmce_in_if in_ch ();
    fmce_out_if out_ch ();

    frame_mic_cmac_engine u_dut (
        .clk(clk), .rst_n(rst_n), .cfg_we(cfg_we), .cfg_index(cfg_index),
        .cfg_data(cfg_data), .in_ch(in_ch.sink), .out_ch(out_ch.source)
    );

    always #5 clk = ~clk;

    // predictor state
    logic [63:0] m_net_hi, m_net_lo, m_dev_hi, m_dev_lo;
    logic [31:0] m_addr;
    logic [127:0] m_chain, m_k1;
    logic [7:0] m_pos, m_mlen;
    logic [31:0] m_rx_mic;
    logic m_join, m_open, m_done;

    mic_result_t mic_q[$];
    int errors = 0;
    int idle_cycles = 0;
    bit no_idle = 1'b0;
    bit hold_off = 1'b0;

    function automatic logic [7:0] mul2(logic [7:0] v);
        return {v[6:0], 1'b0} ^ (v[7] ? 8'h1b : 8'h00);
    endfunction

    // aes-128, byte 0 in bits 127..120
    function automatic logic [127:0] aes128(logic [127:0] blk, logic [127:0] key);
        logic [7:0] s[16], t[16], rk[16], tmp[4];
        logic [7:0] rcon, a0, a1, a2, a3, al;
        logic [127:0] r;
        rcon = 8'h01;
        for (int i = 0; i < 16; i++)
        begin
            rk[i] = key[127-8*i -: 8];
            s[i] = blk[127-8*i -: 8] ^ rk[i];
        end
        for (int rn = 1; rn <= 10; rn++)
        begin
            for (int c = 0; c < 4; c++)
                for (int i = 0; i < 4; i++)
                    t[i+4*c] = SBOX[s[i+4*((c+i)&3)]];
            if (rn < 10)
            begin
                for (int c = 0; c < 4; c++)
                begin
                    a0 = t[4*c]; a1 = t[4*c+1]; a2 = t[4*c+2]; a3 = t[4*c+3];
                    al = a0 ^ a1 ^ a2 ^ a3;
                    t[4*c]   = a0 ^ al ^ mul2(a0 ^ a1);
                    t[4*c+1] = a1 ^ al ^ mul2(a1 ^ a2);
                    t[4*c+2] = a2 ^ al ^ mul2(a2 ^ a3);
                    t[4*c+3] = a3 ^ al ^ mul2(a3 ^ a0);
                end
            end
            tmp[0] = SBOX[rk[13]] ^ rcon;
            tmp[1] = SBOX[rk[14]];
            tmp[2] = SBOX[rk[15]];
            tmp[3] = SBOX[rk[12]];
            rcon = mul2(rcon);
            for (int i = 0; i < 4; i++) rk[i] = rk[i] ^ tmp[i];
            for (int i = 4; i < 16; i++) rk[i] = rk[i] ^ rk[i-4];
            for (int i = 0; i < 16; i++) s[i] = t[i] ^ rk[i];
        end
        for (int i = 0; i < 16; i++) r[127-8*i -: 8] = s[i];
        return r;
    endfunction

    function automatic logic [127:0] gf_double(logic [127:0] v);
        return {v[126:0], 1'b0} ^ {120'd0, (v[127] ? 8'h87 : 8'h00)};
    endfunction

    function automatic logic [127:0] session_key();
        return m_join ? {m_dev_hi, m_dev_lo} : {m_net_hi, m_net_lo};
    endfunction

    function automatic int cmac_bytes();
        int p;
        p = (m_pos < m_mlen) ? m_pos : m_mlen;
        return (m_join ? 0 : 16) + p;
    endfunction

    function automatic void close_cmac();
        int cm;
        logic [127:0] k;
        cm = cmac_bytes();
        k = m_k1;
        if (cm == 0 || (cm % 16) != 0)
        begin
            m_chain[127-8*(cm%16) -: 8] = m_chain[127-8*(cm%16) -: 8] ^ PAD_BYTE;
            k = gf_double(k);
        end
        m_chain = aes128(m_chain ^ k, session_key());
        m_done = 1'b1;
    endfunction

    function automatic void predict_mic(byte_item_t it);
        int cm;
        mic_result_t res;
        if (it.first_byte)
        begin
            m_join = it.join_mode;
            m_mlen = (it.total_len >= 4) ? it.total_len - 8'd4 : 8'd0;
            m_pos = 0;
            m_rx_mic = 0;
            m_open = 1'b1;
            m_done = 1'b0;
            m_k1 = gf_double(aes128(128'd0, session_key()));
            m_chain = '0;
            if (!m_join)
            begin
                m_chain[127 -: 8] = B0_TAG;
                m_chain[127-40 -: 8] = {7'd0, it.downlink};
                for (int i = 0; i < 4; i++)
                begin
                    m_chain[127-8*(6+i) -: 8] = m_addr[8*i +: 8];
                    m_chain[127-8*(10+i) -: 8] = it.frame_count[8*i +: 8];
                end
                m_chain[7:0] = m_mlen;
            end
            if (m_mlen == 0) close_cmac();
        end
        if (!m_open) return;
        if (m_pos < m_mlen)
        begin
            cm = cmac_bytes();
            if (cm != 0 && (cm % 16) == 0) m_chain = aes128(m_chain, session_key());
            m_chain[127-8*(cm%16) -: 8] = m_chain[127-8*(cm%16) -: 8] ^ it.data_byte;
        end
        else
            m_rx_mic = {it.data_byte, m_rx_mic[31:8]};
        if (m_pos < 8'd255) m_pos++;
        if (!m_done && m_pos == m_mlen) close_cmac();
        if (!it.last_byte) return;
        if (!m_done) close_cmac();
        res.mic = {m_chain[103:96], m_chain[111:104], m_chain[119:112], m_chain[127:120]};
        res.mic_match = (m_rx_mic == res.mic);
        mic_q.push_back(res);
        m_open = 1'b0;
    endfunction

    // the caller drops cfg_we after the last write of a batch
    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [63:0] val);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(posedge clk);
        case (idx)
            REG_NET_KEY_HIGH: m_net_hi = val;
            REG_NET_KEY_LOW: m_net_lo = val;
            REG_DEV_KEY_HIGH: m_dev_hi = val;
            REG_DEV_KEY_LOW: m_dev_lo = val;
            default: m_addr = val[31:0];
        endcase
    endtask

    // drive one item until accepted, predicting on acceptance
    task automatic send_byte(byte_item_t it);
        while (!no_idle && $urandom_range(99) < 11)
        begin
            in_ch.valid <= 1'b0;
            @(posedge clk);
        end
        in_ch.valid <= 1'b1;
        {in_ch.data_byte, in_ch.first_byte, in_ch.last_byte, in_ch.join_mode,
         in_ch.downlink, in_ch.frame_count, in_ch.total_len} <= it;
        do @(posedge clk); while (!in_ch.ready);
        predict_mic(it);
    endtask

    task automatic drain();
        in_ch.valid <= 1'b0;
        while (mic_q.size() != 0) @(posedge clk);
        repeat (60) @(posedge clk);
    endtask

    task automatic send_frame(logic jm, logic dl, logic [31:0] fc, logic [7:0] tl,
                              int n, bit good_mic);
        byte_item_t it;
        logic [7:0] msg_len;
        logic [31:0] exp_mic;
        msg_len = (tl >= 4) ? tl - 8'd4 : 8'd0;
        for (int i = 0; i < n; i++)
        begin
            it.data_byte = $urandom_range(255);
            it.first_byte = (i == 0);
            it.last_byte = (i == n - 1);
            it.join_mode = (i == 0) ? jm : logic'($urandom_range(1));
            it.downlink = (i == 0) ? dl : logic'($urandom_range(1));
            it.frame_count = (i == 0) ? fc : $urandom;
            it.total_len = (i == 0) ? tl : 8'($urandom_range(255));
            // feed the predicted mic back so matches happen
            if (good_mic && i >= msg_len && i < msg_len + 4 && m_done && m_open)
            begin
                exp_mic = {m_chain[103:96], m_chain[111:104],
                           m_chain[119:112], m_chain[127:120]};
                it.data_byte = exp_mic[8*(i-msg_len) +: 8];
            end
            send_byte(it);
        end
    endtask

    initial
    begin
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
    end

    always @(posedge clk)
    begin
        if (!rst_n)
            out_ch.ready <= 1'b0;
        else
            out_ch.ready <= !hold_off && (no_idle || $urandom_range(99) >= 11);
    end

    always @(posedge clk)
    begin
        mic_result_t want;
        if (rst_n && out_ch.valid && out_ch.ready)
        begin
            if (mic_q.size() == 0)
            begin
                $error("mic result with no expectation: %h", out_ch.mic);
                errors++;
            end
            else
            begin
                want = mic_q.pop_front();
                if (out_ch.mic !== want.mic)
                begin
                    $error("mic: expected %h actual %h", want.mic, out_ch.mic);
                    errors++;
                end
                if (out_ch.mic_match !== want.mic_match)
                begin
                    $error("mic_match: expected %0d actual %0d", want.mic_match,
                           out_ch.mic_match);
                    errors++;
                end
            end
        end
    end

    always @(posedge clk)
    begin
        if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles > IDLE_LIMIT)
        begin
            $display("end of test: mismatches");
            $finish;
        end
    end

    dir_row_t dir_rows[$];

    initial
    begin
        byte_item_t it;
        int sent;
        in_ch.valid = 1'b0;
        {in_ch.data_byte, in_ch.first_byte, in_ch.last_byte, in_ch.join_mode,
         in_ch.downlink, in_ch.frame_count, in_ch.total_len} = '0;
        m_net_hi = 0; m_net_lo = 0; m_dev_hi = 0; m_dev_lo = 0; m_addr = 0;
        m_chain = 0; m_k1 = 0; m_pos = 0; m_mlen = 0; m_rx_mic = 0;
        m_join = 0; m_open = 0; m_done = 0;
        @(posedge rst_n);
        @(posedge clk);

        // directed: stray byte, short lengths, early, late, restart
        it = '{8'hff, 1'b0, 1'b1, 1'b1, 1'b1, 32'hffffffff, 8'hff};
        dir_rows.push_back('{it, 1'b0, '0});
        it = '{8'h00, 1'b1, 1'b1, 1'b1, 1'b0, 32'h0, 8'd0};
        dir_rows.push_back('{it, 1'b0, '0});
        it = '{8'hff, 1'b1, 1'b1, 1'b0, 1'b1, 32'hffffffff, 8'd3};
        dir_rows.push_back('{it, 1'b0, '0});
        it = '{8'h5a, 1'b1, 1'b0, 1'b0, 1'b0, 32'h0, 8'd255};
        dir_rows.push_back('{it, 1'b0, '0});
        it = '{8'ha5, 1'b1, 1'b0, 1'b1, 1'b0, 32'h1, 8'd20};
        dir_rows.push_back('{it, 1'b0, '0});
        for (int i = 0; i < 17; i++)
        begin
            it = '{8'(i * 37), 1'b0, (i == 16), 1'b0, 1'b0, 32'h0, 8'd0};
            dir_rows.push_back('{it, 1'b0, '0});
        end
        foreach (dir_rows[r])
        begin
            send_byte(dir_rows[r].item);
            if (dir_rows[r].has_mic && mic_q.size() != 0)
                mic_q[$] = dir_rows[r].mic_val;
        end
        drain();

        // one key and address setting at the all-ones extreme, then directed frames
        write_reg(REG_NET_KEY_HIGH, '1);
        write_reg(REG_NET_KEY_LOW, '1);
        write_reg(REG_DEV_KEY_HIGH, '1);
        write_reg(REG_DEV_KEY_LOW, '1);
        write_reg(REG_DEV_ADDR, 64'hffffffff);
        cfg_we <= 1'b0;
        send_frame(1'b0, 1'b1, 32'hffffffff, 8'd4, 4, 1'b1);
        send_frame(1'b1, 1'b0, 32'h0, 8'd4, 4, 1'b1);
        send_frame(1'b0, 1'b0, 32'h12345678, 8'd20, 20, 1'b1);
        send_frame(1'b1, 1'b1, 32'h0, 8'd36, 36, 1'b0);
        drain();

        sent = 0;
        for (int phase = 0; phase < 4; phase++)
        begin
            write_reg(REG_NET_KEY_HIGH, {$urandom, $urandom});
            write_reg(REG_NET_KEY_LOW, {$urandom, $urandom});
            write_reg(REG_DEV_KEY_HIGH, {$urandom, $urandom});
            write_reg(REG_DEV_KEY_LOW, {$urandom, $urandom});
            write_reg(REG_DEV_ADDR, {32'd0, $urandom});
            cfg_we <= 1'b0;
            no_idle = (phase == 1);
            if (phase == 2)
                fork
                    begin
                        hold_off = 1'b1;
                        repeat (400) @(posedge clk);
                        hold_off = 1'b0;
                    end
                join_none
            while (sent < 300 * (phase + 1))
            begin
                int tl, n, kind;
                kind = $urandom_range(9);
                tl = ($urandom_range(9) == 0) ? $urandom_range(255) : $urandom_range(4, 40);
                n = tl;
                if (kind == 0) n = $urandom_range(1, tl + 3);
                else if (kind == 1) n = tl + $urandom_range(1, 6);
                if (n < 1) n = 1;
                if (kind == 2)
                begin
                    it = '{8'($urandom), 1'b0, 1'($urandom), 1'($urandom), 1'($urandom),
                           $urandom, 8'($urandom)};
                    send_byte(it);
                    n = 1;
                end
                else
                    send_frame(1'($urandom), 1'($urandom), $urandom, 8'(tl), n,
                               $urandom_range(1));
                sent += n;
            end
            drain();
        end
        no_idle = 1'b0;

        if (errors == 0 && mic_q.size() == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end
endmodule
`default_nettype wire

// ===== frame_mic_cmac_engine.f =====
rtl/fmce_pkg.sv
rtl/fmce_in_if.sv
rtl/fmce_out_if.sv
rtl/fmce_aes.sv
rtl/fmce_datapath.sv
rtl/fmce_ctrl.sv
rtl/frame_mic_cmac_engine.sv
verif/fmce_tb_if.sv
verif/frame_mic_cmac_engine_tb.sv
